@@ hdl/pll_counter_word_sequencer_assert.svh @@
// Assertion macros for the PLL counter word sequencer.
`ifndef PLL_COUNTER_WORD_SEQUENCER_ASSERT_SVH
`define PLL_COUNTER_WORD_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define PCWS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcws assertion failed");
// Check a property on every edge, reset included.
`define PCWS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcws assertion failed");
`else
`define PCWS_ASSERT(label, clk, rst_n, prop)
`define PCWS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ hdl/pcws_pkg.sv @@
// Types and constants shared by the PLL counter word sequencer.
`timescale 1ns / 1ps
package pcws_pkg;

    localparam int FREQ_W   = 11;
    localparam int DIVD_W   = 31;
    localparam int DEN_W    = 30;
    localparam int STEP_W   = 5;
    localparam int WORD_W   = 24;

    localparam logic [11:0] FREQ_MIN_MHZ   = 12'd900;
    localparam logic [11:0] FREQ_MAX_MHZ   = 12'd1500;
    localparam logic [19:0] HZ_PER_MHZ     = 20'd1000000;
    localparam logic [12:0] B_MAX          = 13'd8191;
    localparam logic [2:0]  UPDATE_LIMIT   = 3'd5;
    localparam logic [STEP_W-1:0] DIV_LAST = 5'd30;

    localparam logic [1:0] CTRL_R_WORD = 2'b01;
    localparam logic [1:0] CTRL_C_WORD = 2'b00;
    localparam logic [1:0] CTRL_N_WORD = 2'b10;

    // Configuration register indexes
    localparam logic [2:0] REG_REF_FREQ   = 3'd0;
    localparam logic [2:0] REG_REF_DIV    = 3'd1;
    localparam logic [2:0] REG_PRESCALER  = 3'd2;
    localparam logic [2:0] REG_CONTROL    = 3'd3;
    localparam logic [2:0] REG_NCOUNTER   = 3'd4;
    localparam logic [2:0] REG_RCOUNTER   = 3'd5;

    // Prescaler modes
    localparam logic [1:0] PRESC_8  = 2'd0;
    localparam logic [1:0] PRESC_16 = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_PFD,
        S_MUL,
        S_DIV_N,
        S_PACK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        W_R,
        W_C,
        W_N
    } t_word_sel;

    typedef struct packed {
        logic ready;
        logic div_step;
        logic load_n;
        logic pack;
        logic emit_ok;
    } t_seq_ctl;

endpackage

@@ hdl/pll_counter_word_sequencer.sv @@
// Top level: request to R, control and N latch word sequencer for an A/B counter PLL.
`timescale 1ns / 1ps
// Each request word carries a frequency in MHz (clamped to 900..1500) and a
// full/incremental flag. The block computes PFD = ref_freq_hz / ref_divider and
// N = freq * 1e6 / PFD with one shared restoring divider, one quotient bit per
// clock; the multiply by 1e6 sits between the two divisions in a registered
// stage. B = N / prescaler (saturated at 8191) and A = N mod prescaler are
// packed into the N latch word. In full write mode the R, control and N words
// come out in that order, else only the N word; tlast marks the final word.
// After the accepting clock, tready stays low through both divisions, the
// multiply, the packing and the emission of the words; a word that waits on
// the output side during emission holds it low for longer. The last word sits
// in the output register, so the next request is taken while it waits.
// Configuration is written through a plain write port (index = register
// number); the user must write it only while idle, which the block itself does
// not enforce; writes to indexes 6 and 7 are dropped.
module pll_counter_word_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] freq_mhz, [15:12] zero
    input  logic        i_s_axis_tuser,   // [0] req_type
    // latch word stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] latch_word
    output logic        o_m_axis_tlast,   // last_word
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [29:0] i_cfg_data
);

    `include "pll_counter_word_sequencer_assert.svh"

    // configuration registers
    logic [29:0] r_ref_freq_hz;
    logic [13:0] r_ref_divider;
    logic [1:0]  r_prescaler_mode;
    logic [19:0] r_control_settings;
    logic [2:0]  r_ncounter_settings;
    logic [5:0]  r_rcounter_settings;

    // request state
    logic [2:0] r_update_count;
    logic       r_write_mode;

    // sequencer and datapath
    pcws_pkg::t_state    r_state, n_state;
    pcws_pkg::t_seq_ctl  w_ctl;
    pcws_pkg::t_word_sel r_word_sel;
    logic [pcws_pkg::FREQ_W-1:0] r_freq;
    logic [pcws_pkg::DIVD_W-1:0] r_quo;
    logic [pcws_pkg::DEN_W-1:0]  r_den;
    logic [pcws_pkg::DEN_W-1:0]  r_rem;
    logic [pcws_pkg::STEP_W-1:0] r_step;
    logic [23:0] r_n_word;

    // output register
    logic        r_out_valid;
    logic [23:0] r_out_data;
    logic        r_out_last;

    logic        w_in_accept;
    logic [11:0] w_freq_in;
    logic [pcws_pkg::FREQ_W-1:0] w_freq_clamped;
    logic [pcws_pkg::DEN_W-1:0]  w_divisor;

    assign w_in_accept = i_s_axis_tvalid && w_ctl.ready;
    assign w_freq_in   = i_s_axis_tdata[11:0];
    assign o_s_axis_tready = w_ctl.ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // Clamp the request to 900..1500 MHz.
    always_comb begin
        if (w_freq_in < pcws_pkg::FREQ_MIN_MHZ) begin
            w_freq_clamped = pcws_pkg::FREQ_MIN_MHZ[pcws_pkg::FREQ_W-1:0];
        end else if (w_freq_in > pcws_pkg::FREQ_MAX_MHZ) begin
            w_freq_clamped = pcws_pkg::FREQ_MAX_MHZ[pcws_pkg::FREQ_W-1:0];
        end else begin
            w_freq_clamped = w_freq_in[pcws_pkg::FREQ_W-1:0];
        end
    end

    // A divider of zero divides as one; it still goes into the R word as zero.
    assign w_divisor = (r_ref_divider == '0) ? pcws_pkg::DEN_W'(1)
                                             : pcws_pkg::DEN_W'(r_ref_divider);

    // ---------------------------------------------------------------------
    // Configuration writes
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_freq_hz       <= 30'd100000000;
            r_ref_divider       <= 14'd100;
            r_prescaler_mode    <= 2'd0;
            r_control_settings  <= 20'd261195;
            r_ncounter_settings <= 3'd0;
            r_rcounter_settings <= 6'd48;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pcws_pkg::REG_REF_FREQ:  r_ref_freq_hz       <= i_cfg_data;
                pcws_pkg::REG_REF_DIV:   r_ref_divider       <= i_cfg_data[13:0];
                pcws_pkg::REG_PRESCALER: r_prescaler_mode    <= i_cfg_data[1:0];
                pcws_pkg::REG_CONTROL:   r_control_settings  <= i_cfg_data[19:0];
                pcws_pkg::REG_NCOUNTER:  r_ncounter_settings <= i_cfg_data[2:0];
                pcws_pkg::REG_RCOUNTER:  r_rcounter_settings <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcws_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) n_state = pcws_pkg::S_DIV_PFD;
            end
            pcws_pkg::S_DIV_PFD: begin
                if (r_step == pcws_pkg::DIV_LAST) n_state = pcws_pkg::S_MUL;
            end
            pcws_pkg::S_MUL: begin
                n_state = pcws_pkg::S_DIV_N;
            end
            pcws_pkg::S_DIV_N: begin
                if (r_step == pcws_pkg::DIV_LAST) n_state = pcws_pkg::S_PACK;
            end
            pcws_pkg::S_PACK: begin
                n_state = pcws_pkg::S_EMIT;
            end
            pcws_pkg::S_EMIT: begin
                if (w_ctl.emit_ok && r_word_sel == pcws_pkg::W_N) begin
                    n_state = pcws_pkg::S_IDLE;
                end
            end
            default: n_state = pcws_pkg::S_IDLE;
        endcase
    end

    // Sequencer: control outputs
    always_comb begin
        w_ctl = '0;
        case (r_state)
            pcws_pkg::S_IDLE:    w_ctl.ready    = 1'b1;
            pcws_pkg::S_DIV_PFD: w_ctl.div_step = 1'b1;
            pcws_pkg::S_MUL:     w_ctl.load_n   = 1'b1;
            pcws_pkg::S_DIV_N:   w_ctl.div_step = 1'b1;
            pcws_pkg::S_PACK:    w_ctl.pack     = 1'b1;
            pcws_pkg::S_EMIT:    w_ctl.emit_ok  = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // Update count and write mode, advanced on each accepted request
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_update_count <= '0;
            r_write_mode   <= 1'b0;
        end else if (w_in_accept) begin
            if (i_s_axis_tuser) begin
                // full request: restart the count, keep the mode
                r_update_count <= '0;
            end else if (r_update_count < pcws_pkg::UPDATE_LIMIT) begin
                r_update_count <= r_update_count + 3'd1;
                r_write_mode   <= 1'b0;
            end else begin
                r_write_mode   <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Shared restoring divider: one quotient bit per clock
    // ---------------------------------------------------------------------
    logic [pcws_pkg::DIVD_W-1:0] w_rem_shift;
    logic [pcws_pkg::DIVD_W:0]   w_diff;
    logic                        w_ge;
    logic [pcws_pkg::DIVD_W-1:0] w_product;
    logic [pcws_pkg::DEN_W-1:0]  w_pfd;

    assign w_rem_shift = {r_rem, r_quo[pcws_pkg::DIVD_W-1]};
    assign w_diff      = {1'b0, w_rem_shift} - {2'b00, r_den};
    assign w_ge        = !w_diff[pcws_pkg::DIVD_W];
    assign w_product   = pcws_pkg::DIVD_W'(r_freq) * pcws_pkg::DIVD_W'(pcws_pkg::HZ_PER_MHZ);
    // PFD fits 30 bits; a zero comparison frequency is taken as one.
    assign w_pfd = (r_quo == '0) ? pcws_pkg::DEN_W'(1) : r_quo[pcws_pkg::DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_freq <= w_freq_clamped;
            r_quo  <= {1'b0, r_ref_freq_hz};
            r_den  <= w_divisor;
            r_rem  <= '0;
        end else if (w_ctl.load_n) begin
            // hold PFD as the divisor, load freq * 1e6 as the dividend
            r_quo  <= w_product;
            r_den  <= w_pfd;
            r_rem  <= '0;
        end else if (w_ctl.div_step) begin
            r_quo  <= {r_quo[pcws_pkg::DIVD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[pcws_pkg::DEN_W-1:0] : w_rem_shift[pcws_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (w_ctl.div_step) begin
            r_step <= (r_step == pcws_pkg::DIV_LAST) ? '0 : r_step + 5'd1;
        end else begin
            r_step <= '0;
        end
    end

    // ---------------------------------------------------------------------
    // N word packing: B = N / P saturated, A = N mod P
    // ---------------------------------------------------------------------
    logic [27:0] w_b_full;
    logic [4:0]  w_a;
    logic [12:0] w_b;

    always_comb begin
        case (r_prescaler_mode)
            pcws_pkg::PRESC_8: begin
                w_b_full = 28'(r_quo >> 3);
                w_a      = {2'b00, r_quo[2:0]};
            end
            pcws_pkg::PRESC_16: begin
                w_b_full = 28'(r_quo >> 4);
                w_a      = {1'b0, r_quo[3:0]};
            end
            default: begin
                w_b_full = 28'(r_quo >> 5);
                w_a      = r_quo[4:0];
            end
        endcase
        w_b = (w_b_full > 28'(pcws_pkg::B_MAX)) ? pcws_pkg::B_MAX : w_b_full[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.pack) begin
            r_n_word <= {r_ncounter_settings, w_b, 1'b0, w_a, pcws_pkg::CTRL_N_WORD};
        end
    end

    // ---------------------------------------------------------------------
    // Word emission into the output register
    // ---------------------------------------------------------------------
    logic [23:0] w_emit_word;

    always_comb begin
        case (r_word_sel)
            pcws_pkg::W_R: w_emit_word = {2'b00, r_rcounter_settings, r_ref_divider,
                                          pcws_pkg::CTRL_R_WORD};
            pcws_pkg::W_C: w_emit_word = {r_prescaler_mode, r_control_settings,
                                          pcws_pkg::CTRL_C_WORD};
            default:       w_emit_word = r_n_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_sel <= pcws_pkg::W_R;
        end else if (w_ctl.pack) begin
            r_word_sel <= r_write_mode ? pcws_pkg::W_N : pcws_pkg::W_R;
        end else if (w_ctl.emit_ok) begin
            case (r_word_sel)
                pcws_pkg::W_R: r_word_sel <= pcws_pkg::W_C;
                pcws_pkg::W_C: r_word_sel <= pcws_pkg::W_N;
                default:       r_word_sel <= pcws_pkg::W_R;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit_ok) begin
            r_out_data <= w_emit_word;
            r_out_last <= (r_word_sel == pcws_pkg::W_N);
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `PCWS_ASSERT(a_count_bound, i_clk, i_rst_n, r_update_count <= pcws_pkg::UPDATE_LIMIT)
    `PCWS_ASSERT(a_last_is_n_word, i_clk, i_rst_n,
        (r_out_valid && r_out_last) |-> (r_out_data[1:0] == pcws_pkg::CTRL_N_WORD))
    `PCWS_ASSERT(a_n_only_mode, i_clk, i_rst_n, (r_out_valid && r_write_mode) |-> r_out_last)
    `PCWS_ASSERT(a_accept_starts_div, i_clk, i_rst_n,
        w_in_accept |=> (r_state == pcws_pkg::S_DIV_PFD))
    `PCWS_ASSERT(a_rem_below_den, i_clk, i_rst_n,
        ((r_state == pcws_pkg::S_DIV_PFD) || (r_state == pcws_pkg::S_DIV_N)) |-> (r_rem < r_den))

endmodule
